// ----- src/bps_pkg.sv -----
package bps_pkg;

    localparam int FRAC_W    = 8;   // fraction bits of a sample coordinate
    localparam int COORD_W   = 8;   // integer pixel coordinate
    localparam int SAMPLE_W  = 17;  // signed sample coordinate
    localparam int PIX_W     = 16;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_MIN   = 2;
    localparam int DIM_RST   = 256;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // weight of a whole pixel step, 1.0 in 8 fraction bits
    localparam logic [FRAC_W:0] WEIGHT_ONE = 9'd256;

endpackage

// ----- src/bps_ram.sv -----
module bps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- src/bilinear_pixel_sampler.sv -----
// Channel  Handshake            Beat
// in       i_valid / o_ready    i_req_type, i_write_x/y, i_write_value, i_sample_col/row
// out      o_valid / i_ready    o_sample_value, o_sample_inside
// cfg      i_cfg_we             i_cfg_idx, i_cfg_data (no handshake back)
//
// One beat in and one out per cycle while i_ready is high; stages are decode, address
// multiply, pixel store read, column blend, row blend into the output register.
// The store is two banks split on address parity, each read at two addresses a
// cycle, so all four neighbours come out of one read.
// i_rst_n (synchronous) clears valid bits, sets each dimension to min(256, MAX_*);
// the store keeps no reset. A full stage holds when the stage after it is held.
module bilinear_pixel_sampler
    import bps_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_req_type,
    input  logic [COORD_W-1:0]         i_write_x,
    input  logic [COORD_W-1:0]         i_write_y,
    input  logic [PIX_W-1:0]           i_write_value,
    input  logic signed [SAMPLE_W-1:0] i_sample_col,
    input  logic signed [SAMPLE_W-1:0] i_sample_row,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [PIX_W-1:0]           o_sample_value,
    output logic                       o_sample_inside
);

    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(DEPTH);
    localparam int BANK_DEPTH = (DEPTH + 1) / 2;
    localparam int BAW        = $clog2(BANK_DEPTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int PW         = COORD_W + 1 + WW;
    localparam int W_RST      = (MAX_WIDTH < DIM_RST) ? MAX_WIDTH : DIM_RST;
    localparam int H_RST      = (MAX_HEIGHT < DIM_RST) ? MAX_HEIGHT : DIM_RST;
    localparam int HSUM_W     = PIX_W + FRAC_W;       // one row blended
    localparam int ACC_W      = PIX_W + 2 * FRAC_W + 1;

    // ---------------- configuration ----------------
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(W_RST);
            r_height <= HW'(H_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH: begin
                    if (32'(i_cfg_data) < DIM_MIN) begin
                        r_width <= WW'(DIM_MIN);
                    end else if (32'(i_cfg_data) > MAX_WIDTH) begin
                        r_width <= WW'(MAX_WIDTH);
                    end else begin
                        r_width <= WW'(i_cfg_data);
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    if (32'(i_cfg_data) < DIM_MIN) begin
                        r_height <= HW'(DIM_MIN);
                    end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
                        r_height <= HW'(MAX_HEIGHT);
                    end else begin
                        r_height <= HW'(i_cfg_data);
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- stage enables ----------------
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r5_valid || i_ready;
    assign en4 = !r4_valid || en5;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;

    assign o_ready = en1;

    // ---------------- stage 1: decode ----------------
    logic [COORD_W-1:0] n1_ic, n1_ir, n1_fx, n1_fy;
    logic               n1_neg, n1_smp_ok, n1_wr_ok;
    logic [COORD_W-1:0] n1_col, n1_row;

    assign n1_ic  = i_sample_col[FRAC_W +: COORD_W];
    assign n1_ir  = i_sample_row[FRAC_W +: COORD_W];
    assign n1_fx  = i_sample_col[FRAC_W-1:0];
    assign n1_fy  = i_sample_row[FRAC_W-1:0];
    assign n1_neg = i_sample_col[SAMPLE_W-1] | i_sample_row[SAMPLE_W-1];

    // the last row and column have no right or lower neighbour
    assign n1_smp_ok = (i_req_type == REQ_SAMPLE) && !n1_neg
                    && (32'(n1_ic) + 32'd1 < 32'(r_width))
                    && (32'(n1_ir) + 32'd1 < 32'(r_height));
    assign n1_wr_ok  = (i_req_type == REQ_WRITE)
                    && (32'(i_write_x) < 32'(r_width))
                    && (32'(i_write_y) < 32'(r_height));

    // unused coordinates are zeroed so addresses stay in the store
    assign n1_col = n1_smp_ok ? n1_ic : (n1_wr_ok ? i_write_x : '0);
    assign n1_row = n1_smp_ok ? n1_ir : (n1_wr_ok ? i_write_y : '0);

    logic               r1_smp_ok, r1_wr_ok;
    logic [COORD_W-1:0] r1_col, r1_row, r1_fx, r1_fy;
    logic [PIX_W-1:0]   r1_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_valid;
        end
        if (en1) begin
            r1_smp_ok <= n1_smp_ok;
            r1_wr_ok  <= n1_wr_ok;
            r1_col    <= n1_col;
            r1_row    <= n1_row;
            r1_fx     <= n1_fx;
            r1_fy     <= n1_fy;
            r1_value  <= i_write_value;
        end
    end

    // ---------------- stage 2: row-major addresses ----------------
    logic [COORD_W:0] n2_row1;
    logic [AW-1:0]    n2_addr_a, n2_addr_b;

    assign n2_row1   = {1'b0, r1_row} + 1'b1;
    assign n2_addr_a = AW'(PW'(r1_row) * PW'(r_width) + PW'(r1_col));
    assign n2_addr_b = AW'(PW'(n2_row1) * PW'(r_width) + PW'(r1_col));

    logic               r2_smp_ok, r2_wr_ok;
    logic [AW-1:0]      r2_addr_a, r2_addr_b;
    logic [COORD_W-1:0] r2_fx, r2_fy;
    logic [PIX_W-1:0]   r2_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
        if (en2) begin
            r2_smp_ok <= r1_smp_ok;
            r2_wr_ok  <= r1_wr_ok;
            r2_addr_a <= n2_addr_a;
            r2_addr_b <= n2_addr_b;
            r2_fx     <= r1_fx;
            r2_fy     <= r1_fy;
            r2_value  <= r1_value;
        end
    end

    // ---------------- pixel store: even / odd address banks ----------------
    // Of addr and addr+1 the odd one sits at addr>>1 in the odd bank, the even
    // one at (addr>>1)+addr[0] in the even bank.
    logic           wr_go;
    logic [BAW-1:0] odd_addr_a, odd_addr_b, even_addr_a, even_addr_b, wr_addr;
    logic [PIX_W-1:0] q_even_a, q_even_b, q_odd_a, q_odd_b;

    assign wr_go       = r2_valid && r2_wr_ok && en3;
    assign wr_addr     = BAW'(r2_addr_a >> 1);
    assign odd_addr_a  = BAW'(r2_addr_a >> 1);
    assign odd_addr_b  = BAW'(r2_addr_b >> 1);
    assign even_addr_a = BAW'((r2_addr_a >> 1) + AW'(r2_addr_a[0]));
    assign even_addr_b = BAW'((r2_addr_b >> 1) + AW'(r2_addr_b[0]));

    bps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .i_clk     (i_clk),
        .i_we      (wr_go && !r2_addr_a[0]),
        .i_waddr   (wr_addr),
        .i_wdata   (r2_value),
        .i_re      (en3),
        .i_raddr_a (even_addr_a),
        .i_raddr_b (even_addr_b),
        .o_rdata_a (q_even_a),
        .o_rdata_b (q_even_b)
    );

    bps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .i_clk     (i_clk),
        .i_we      (wr_go && r2_addr_a[0]),
        .i_waddr   (wr_addr),
        .i_wdata   (r2_value),
        .i_re      (en3),
        .i_raddr_a (odd_addr_a),
        .i_raddr_b (odd_addr_b),
        .o_rdata_a (q_odd_a),
        .o_rdata_b (q_odd_b)
    );

    // ---------------- stage 3: alongside the store read ----------------
    logic               r3_smp_ok, r3_par_a, r3_par_b;
    logic [COORD_W-1:0] r3_fx, r3_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
        if (en3) begin
            r3_smp_ok <= r2_smp_ok;
            r3_par_a  <= r2_addr_a[0];
            r3_par_b  <= r2_addr_b[0];
            r3_fx     <= r2_fx;
            r3_fy     <= r2_fy;
        end
    end

    // ---------------- stage 4: blend along each row ----------------
    logic [PIX_W-1:0]  p00, p01, p10, p11;
    logic [FRAC_W:0]   n4_wx0;
    logic [HSUM_W-1:0] n4_top, n4_bot;

    assign p00 = r3_par_a ? q_odd_a  : q_even_a;
    assign p01 = r3_par_a ? q_even_a : q_odd_a;
    assign p10 = r3_par_b ? q_odd_b  : q_even_b;
    assign p11 = r3_par_b ? q_even_b : q_odd_b;

    assign n4_wx0 = WEIGHT_ONE - {1'b0, r3_fx};
    assign n4_top = HSUM_W'((HSUM_W + 1)'(n4_wx0) * (HSUM_W + 1)'(p00)
                          + (HSUM_W + 1)'(r3_fx) * (HSUM_W + 1)'(p01));
    assign n4_bot = HSUM_W'((HSUM_W + 1)'(n4_wx0) * (HSUM_W + 1)'(p10)
                          + (HSUM_W + 1)'(r3_fx) * (HSUM_W + 1)'(p11));

    logic              r4_smp_ok;
    logic [COORD_W-1:0] r4_fy;
    logic [HSUM_W-1:0] r4_top, r4_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en4) begin
            r4_valid <= r3_valid;
        end
        if (en4) begin
            r4_smp_ok <= r3_smp_ok;
            r4_fy     <= r3_fy;
            r4_top    <= n4_top;
            r4_bot    <= n4_bot;
        end
    end

    // ---------------- stage 5: blend the two rows, output register ----------------
    logic [FRAC_W:0]  n5_wy0;
    logic [ACC_W-1:0] n5_acc;

    assign n5_wy0 = WEIGHT_ONE - {1'b0, r4_fy};
    assign n5_acc = ACC_W'(n5_wy0) * ACC_W'(r4_top) + ACC_W'(r4_fy) * ACC_W'(r4_bot);

    logic [PIX_W-1:0] r5_value;
    logic             r5_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en5) begin
            r5_valid <= r4_valid;
        end
        if (en5) begin
            r5_inside <= r4_smp_ok;
            r5_value  <= r4_smp_ok ? n5_acc[2 * FRAC_W +: PIX_W] : '0;
        end
    end

    assign o_valid         = r5_valid;
    assign o_sample_value  = r5_value;
    assign o_sample_inside = r5_inside;

endmodule
